@@ hdl/ard_pkg.sv @@
// Shared types, constants and the microcode table of the recursive doubling schedule block.
`timescale 1ns / 1ps

package ard_pkg;

  localparam int RANK_W  = 10;
  localparam int COUNT_W = 11;
  localparam int BYTES_W = 31;
  localparam int STEP_W  = 4;

  localparam logic REG_RANK_COUNT    = 1'b0;
  localparam logic REG_MESSAGE_BYTES = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_SETUP      = 4'd0;
  localparam step_t ST_BR_EMPTY   = 4'd1;
  localparam step_t ST_BR_EVEN    = 4'd2;
  localparam step_t ST_BR_NOFOLD  = 4'd3;
  localparam step_t ST_FOLD_RECV  = 4'd4;
  localparam step_t ST_RND_SEND   = 4'd5;
  localparam step_t ST_RND_RECV   = 4'd6;
  localparam step_t ST_BR_TAIL    = 4'd7;
  localparam step_t ST_TAIL_SEND  = 4'd8;
  localparam step_t ST_EVEN_SEND  = 4'd9;
  localparam step_t ST_EVEN_RECV  = 4'd10;
  localparam step_t ST_DONE       = 4'd11;
  localparam step_t ST_NONE       = 4'd12;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_NONE = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    PEER_ZERO,
    PEER_UP,
    PEER_DN,
    PEER_ROUND
  } peer_sel_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_ROUND
  } last_sel_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_EMPTY,
    JC_FOLD_EVEN,
    JC_NOT_FOLD,
    JC_ROUNDS_LEFT
  } jcond_t;

  typedef struct packed {
    logic      setup;
    logic      emit;
    op_kind_t  kind;
    peer_sel_t peer_sel;
    logic      wait_en;
    logic      set_recv;
    logic      shift_mask;
    last_sel_t last_sel;
    jcond_t    jcond;
    step_t     target;
    logic      done;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic fold_even;
    logic in_fold;
    logic final_round;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t cw;
    cw = '0;
    case (s)
      ST_SETUP: begin
        cw.setup = 1'b1;
      end
      ST_BR_EMPTY: begin
        cw.jcond  = JC_EMPTY;
        cw.target = ST_NONE;
      end
      ST_BR_EVEN: begin
        cw.jcond  = JC_FOLD_EVEN;
        cw.target = ST_EVEN_SEND;
      end
      ST_BR_NOFOLD: begin
        cw.jcond  = JC_NOT_FOLD;
        cw.target = ST_RND_SEND;
      end
      ST_FOLD_RECV: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_RECV;
        cw.peer_sel = PEER_DN;
        cw.set_recv = 1'b1;
      end
      ST_RND_SEND: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_SEND;
        cw.peer_sel = PEER_ROUND;
        cw.wait_en  = 1'b1;
      end
      ST_RND_RECV: begin
        cw.emit       = 1'b1;
        cw.kind       = OP_RECV;
        cw.peer_sel   = PEER_ROUND;
        cw.set_recv   = 1'b1;
        cw.shift_mask = 1'b1;
        cw.last_sel   = LAST_ROUND;
        cw.jcond      = JC_ROUNDS_LEFT;
        cw.target     = ST_RND_SEND;
      end
      ST_BR_TAIL: begin
        cw.jcond  = JC_NOT_FOLD;
        cw.target = ST_DONE;
      end
      ST_TAIL_SEND: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_SEND;
        cw.peer_sel = PEER_DN;
        cw.wait_en  = 1'b1;
        cw.last_sel = LAST_YES;
        cw.jcond    = JC_ALWAYS;
        cw.target   = ST_DONE;
      end
      ST_EVEN_SEND: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_SEND;
        cw.peer_sel = PEER_UP;
      end
      ST_EVEN_RECV: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_RECV;
        cw.peer_sel = PEER_UP;
        cw.last_sel = LAST_YES;
      end
      ST_DONE: begin
        cw.done = 1'b1;
      end
      ST_NONE: begin
        cw.emit     = 1'b1;
        cw.kind     = OP_NONE;
        cw.peer_sel = PEER_ZERO;
        cw.last_sel = LAST_YES;
        cw.jcond    = JC_ALWAYS;
        cw.target   = ST_DONE;
      end
      default: begin
        cw.done = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ hdl/allreduce_recursive_doubling_schedule.sv @@
// Top level of the recursive doubling allreduce schedule generator.
`timescale 1ns / 1ps

// Each input beat carries one rank; the block answers with that rank's allreduce
// schedule as a run of output beats, one send or receive per beat, the final one
// marked by tlast. An empty schedule (one rank, or a rank not below the rank count)
// gives a single beat of kind none. A rank count above MAX_RANKS is treated as
// MAX_RANKS. A microcode sequencer walks one control word per cycle, and holds on a
// step that emits a beat while the last result beat waits on m_axis_tready. A rank
// has at most 20 operations (1024 ranks, or an odd folding rank with 513 to 1023
// ranks), and the next rank is taken only after the sequencer has left its done step.
// Registers are to be written through the cfg channel only while no schedule is
// running; the block itself does not enforce this.
module allreduce_recursive_doubling_schedule
  import ard_pkg::*;
#(
  parameter int MAX_RANKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rank[9:0], zero[15:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // peer_rank[9:0], op_bytes[40:10], waits_on_recv[41]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,  // op_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  logic [COUNT_W-1:0] rank_count;
  logic [BYTES_W-1:0] message_bytes;
  logic               busy;
  logic               fire;
  logic               start;
  ctrl_t              ctrl;
  status_t            status;
  op_kind_t           out_kind;
  logic [RANK_W-1:0]  out_peer;
  logic [BYTES_W-1:0] out_bytes;
  logic               out_wait;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count    <= COUNT_W'(1);
      message_bytes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RANK_COUNT:    rank_count    <= cfg_data[COUNT_W-1:0];
        REG_MESSAGE_BYTES: message_bytes <= cfg_data;
        default:           rank_count    <= rank_count;
      endcase
    end
  end

  ard_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .fire   (fire),
    .ctrl   (ctrl)
  );

  ard_datapath #(
    .MAX_RANKS (MAX_RANKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .load          (start),
    .rank_in       (s_axis_tdata[RANK_W-1:0]),
    .rank_count    (rank_count),
    .message_bytes (message_bytes),
    .fire          (fire),
    .ctrl          (ctrl),
    .out_ready     (m_axis_tready),
    .status        (status),
    .out_valid     (m_axis_tvalid),
    .out_kind      (out_kind),
    .out_peer      (out_peer),
    .out_bytes     (out_bytes),
    .out_wait      (out_wait),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'b0, out_wait, out_bytes, out_peer};

endmodule

@@ hdl/ard_sequencer.sv @@
// Step counter and microcode fetch with conditional jumps.
`timescale 1ns / 1ps

module ard_sequencer
  import ard_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output logic    fire,
  output ctrl_t   ctrl
);

  step_t step;
  step_t step_next;
  logic  busy_next;
  logic  taken;
  logic  stall;

  always_comb begin
    ctrl = ucode(step);
    case (ctrl.jcond)
      JC_NEVER:       taken = 1'b0;
      JC_ALWAYS:      taken = 1'b1;
      JC_EMPTY:       taken = status.empty;
      JC_FOLD_EVEN:   taken = status.fold_even;
      JC_NOT_FOLD:    taken = !status.in_fold;
      JC_ROUNDS_LEFT: taken = !status.final_round;
      default:        taken = 1'b0;
    endcase
    stall     = ctrl.emit && status.out_busy;
    fire      = busy && !stall;
    step_next = step;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        step_next = ST_SETUP;
      end
    end else if (fire) begin
      if (ctrl.done) begin
        busy_next = 1'b0;
      end else if (taken) begin
        step_next = ctrl.target;
      end else begin
        step_next = step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_SETUP;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

@@ hdl/ard_datapath.sv @@
// Rank folding arithmetic, round peer mapping and the output register.
`timescale 1ns / 1ps

module ard_datapath
  import ard_pkg::*;
#(
  parameter int MAX_RANKS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [RANK_W-1:0]  rank_in,
  input  logic [COUNT_W-1:0] rank_count,
  input  logic [BYTES_W-1:0] message_bytes,
  input  logic               fire,
  input  ctrl_t              ctrl,
  input  logic               out_ready,
  output status_t            status,
  output logic               out_valid,
  output op_kind_t           out_kind,
  output logic [RANK_W-1:0]  out_peer,
  output logic [BYTES_W-1:0] out_bytes,
  output logic               out_wait,
  output logic               out_last
);

  logic [RANK_W-1:0]  rank_r;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] pof2;
  logic [COUNT_W-1:0] vrank;
  logic [COUNT_W-1:0] mask;
  logic               have_recv;
  logic               empty;
  logic               in_fold;
  logic               fold_even;

  logic [COUNT_W-1:0] cnt_c;
  logic [COUNT_W-1:0] pof2_c;
  logic [COUNT_W-1:0] rem_c;
  logic               in_fold_c;
  logic               empty_c;
  logic [COUNT_W-1:0] vrank_c;
  logic [COUNT_W-1:0] vdst;
  logic [COUNT_W-1:0] dst;
  logic               final_round;
  logic [RANK_W-1:0]  peer_c;
  logic               last_c;

  always_comb begin
    cnt_c = rank_count;
    if (32'(rank_count) > 32'(MAX_RANKS)) begin
      cnt_c = COUNT_W'(MAX_RANKS);
    end
    pof2_c = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (cnt_c[i]) begin
        pof2_c = COUNT_W'(1) << i;
      end
    end
    rem_c     = cnt_c - pof2_c;
    empty_c   = (cnt_c <= COUNT_W'(1)) || ({1'b0, rank_r} >= cnt_c);
    in_fold_c = {2'b00, rank_r} < {rem_c, 1'b0};
    if (in_fold_c) begin
      vrank_c = {2'b00, rank_r[RANK_W-1:1]};
    end else begin
      vrank_c = {1'b0, rank_r} - rem_c;
    end
  end

  always_comb begin
    vdst = vrank ^ mask;
    if (vdst < rem) begin
      dst = {vdst[COUNT_W-2:0], 1'b1};
    end else begin
      dst = vdst + rem;
    end
    final_round = (mask == (pof2 >> 1));
    case (ctrl.peer_sel)
      PEER_ZERO:  peer_c = '0;
      PEER_UP:    peer_c = rank_r + RANK_W'(1);
      PEER_DN:    peer_c = rank_r - RANK_W'(1);
      PEER_ROUND: peer_c = dst[RANK_W-1:0];
      default:    peer_c = '0;
    endcase
    case (ctrl.last_sel)
      LAST_NO:    last_c = 1'b0;
      LAST_YES:   last_c = 1'b1;
      LAST_ROUND: last_c = final_round && !in_fold;
      default:    last_c = 1'b0;
    endcase
  end

  assign status.empty       = empty;
  assign status.fold_even   = fold_even;
  assign status.in_fold     = in_fold;
  assign status.final_round = final_round;
  assign status.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      rank_r <= rank_in;
    end
    if (fire && ctrl.setup) begin
      rem       <= rem_c;
      pof2      <= pof2_c;
      vrank     <= vrank_c;
      empty     <= empty_c;
      in_fold   <= in_fold_c;
      fold_even <= in_fold_c && !rank_r[0];
      mask      <= COUNT_W'(1);
    end else if (fire && ctrl.shift_mask) begin
      mask <= mask << 1;
    end
    if (fire && ctrl.emit) begin
      out_kind  <= ctrl.kind;
      out_peer  <= peer_c;
      out_bytes <= (ctrl.kind == OP_NONE) ? '0 : message_bytes;
      out_wait  <= ctrl.wait_en && have_recv;
      out_last  <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      have_recv <= 1'b0;
    end else begin
      if (fire && ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && ctrl.setup) begin
        have_recv <= 1'b0;
      end else if (fire && ctrl.set_recv) begin
        have_recv <= 1'b1;
      end
    end
  end

endmodule
